// File: design/csbr_pkg.sv
// Package with widths, kind codes and reset constants for the bounding radius core.
package csbr_pkg;
  localparam int FRAC_BITS = 8;
  localparam int IN_W = 23;
  localparam int OFS_W = 24;
  localparam int OUT_W = 26;
  localparam int SQ_W = 52;
  localparam int RT_W = 26;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
  localparam logic [OUT_W-1:0] CIRCLE_RESET =
    OUT_W'(((1 << FRAC_BITS) + 50) / 100);

  typedef enum logic [1:0] {
    KIND_SPHERE   = 2'd0,
    KIND_CYLINDER = 2'd1,
    KIND_BOX      = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]       shape_kind;
    logic             shape_enabled;
    logic [IN_W-1:0]  shape_height;
    logic [IN_W-1:0]  major_radius;
    logic [IN_W-1:0]  minor_radius;
    logic [OFS_W-1:0] offset_x;
    logic [OFS_W-1:0] offset_y;
    logic [OFS_W-1:0] offset_z;
    logic             last_shape;
  } shape_t;

  typedef struct packed {
    logic [OUT_W-1:0] circle_radius;
    logic [OUT_W-1:0] sphere_radius;
  } bound_t;
endpackage

// File: design/csbr_if.sv
// Valid/ready stream interfaces for shape requests and bound results.
interface csbr_shape_if import csbr_pkg::*; (input logic clk);
  logic   valid;
  logic   ready;
  shape_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csbr_bound_if import csbr_pkg::*; (input logic clk);
  logic   valid;
  logic   ready;
  bound_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/compound_shape_bounding_radius_core.sv
// Top level: sequencer around one shared multiplier, adder and square-root step.
// A cylinder runs three roots after acceptance and a sphere or box two, each root fed by
// multiply/add steps; a skipped shape goes straight to the fold step, and a last shape
// adds an emit step. A new shape is taken only once the last one is through, and the emit
// step stalls while the output register still holds an unaccepted result. Synchronous reset
// clears the maxima to their starting values and empties the output register.
module compound_shape_bounding_radius_core import csbr_pkg::*; (
  input logic clk,
  input logic rst,
  csbr_shape_if.sink   shape_in,
  csbr_bound_if.source bound_out
);

  // Sequencer steps. The multiply-accumulate unit builds sums of squares in
  // acc; the root unit takes that sum and leaves its floor square root in rt_res.
  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_R2, S_SQZ, S_R3,
    S_CYA, S_CYZ, S_CYR,
    S_BX, S_BY, S_BR2, S_BZ, S_BR3,
    S_FOLD, S_EMIT
  } state_t;

  state_t state, ret;
  shape_t sh;
  logic [OFS_W-1:0] ax, ay, az;
  logic [OFS_W:0] zh;
  logic [SQ_W+1:0] acc;
  logic [RT_W:0] len2, len3, circ, sph;
  // Square-root unit registers. The partial result is kept at the radicand's
  // width, since it carries the current bit weight until the last step.
  logic            rt_busy;
  logic [SQ_W+1:0] rt_v;
  logic [SQ_W+1:0] rt_res;
  logic [5:0]      rt_cnt;
  logic [RT_W:0]   root;
  logic [OUT_W-1:0] circle_max, sphere_max;
  logic out_valid;
  bound_t out_data;
  logic emit_go;

  // Multiplier operand and its product; one multiply per step.
  logic [OFS_W:0]  mop;
  logic [SQ_W-1:0] prod;
  logic [SQ_W+1:0] acc_next;

  function automatic logic [OFS_W-1:0] mag(input logic [OFS_W-1:0] v);
    return v[OFS_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic [RT_W:0] v);
    return v[RT_W] ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  always_comb begin
    case (state)
      S_SQX:   mop = {1'b0, ax};
      S_SQY:   mop = {1'b0, ay};
      S_SQZ:   mop = {1'b0, az};
      S_CYA:   mop = len2[OFS_W:0] + {2'b0, sh.major_radius};
      S_CYZ:   mop = zh;
      S_BX:    mop = {1'b0, ax} + {2'b0, sh.major_radius};
      S_BY:    mop = {1'b0, ay} + {2'b0, sh.minor_radius};
      S_BZ:    mop = zh;
      default: mop = '0;
    endcase
    prod = SQ_W'(mop) * SQ_W'(mop);
    acc_next = acc + {2'b0, prod};
  end

  // Shift-and-subtract root step, two radicand bits per cycle.
  logic [SQ_W+1:0] rt_bit, rt_try;
  assign rt_bit = {{(SQ_W+1){1'b0}}, 1'b1} << {rt_cnt, 1'b0};
  assign rt_try = rt_res + rt_bit;

  // The emit step loads the output register once it is free or being drained.
  assign emit_go = !rt_busy && (state == S_EMIT) && (!out_valid || bound_out.ready);

  assign shape_in.ready = (state == S_IDLE);
  assign bound_out.valid = out_valid;
  assign bound_out.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rt_busy <= 1'b0;
      out_valid <= 1'b0;
      circle_max <= CIRCLE_RESET;
      sphere_max <= '0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (out_valid && bound_out.ready) out_valid <= 1'b0;
      if (rt_busy) begin
        if (rt_v >= rt_try) begin
          rt_v <= rt_v - rt_try;
          rt_res <= (rt_res >> 1) + rt_bit;
        end else begin
          rt_res <= rt_res >> 1;
        end
        rt_cnt <= rt_cnt - 1'b1;
        if (rt_cnt == '0) begin
          rt_busy <= 1'b0;
          state <= ret;
        end
      end else begin
        case (state)
          S_IDLE: if (shape_in.valid) begin
            sh <= shape_in.data;
            ax <= mag(shape_in.data.offset_x);
            ay <= mag(shape_in.data.offset_y);
            az <= mag(shape_in.data.offset_z);
            zh <= {1'b0, mag(shape_in.data.offset_z)} +
                  {2'b0, shape_in.data.shape_height[IN_W-1:1]};
            acc <= '0;
            circ <= '0;
            sph <= '0;
            if (!shape_in.data.shape_enabled ||
                shape_in.data.shape_kind == KIND_NONE) state <= S_FOLD;
            else if (shape_in.data.shape_kind == KIND_BOX) state <= S_BX;
            else state <= S_SQX;
          end
          S_SQX: begin acc <= acc_next; state <= S_SQY; end
          S_SQY: begin
            acc <= acc_next;
            rt_v <= acc_next; rt_res <= '0; rt_cnt <= 6'(RT_W - 1);
            rt_busy <= 1'b1; ret <= S_R2;
          end
          S_R2: begin len2 <= rt_res[RT_W:0]; state <= S_SQZ; end
          S_SQZ: begin
            rt_v <= acc_next; rt_res <= '0; rt_cnt <= 6'(RT_W - 1);
            rt_busy <= 1'b1; ret <= S_R3;
          end
          S_R3: begin
            len3 <= rt_res[RT_W:0];
            if (sh.shape_kind == KIND_SPHERE) begin
              circ <= len2 + {4'b0, sh.major_radius};
              sph <= rt_res[RT_W:0] + {4'b0, sh.major_radius};
              state <= S_FOLD;
            end else begin
              circ <= len2 + {4'b0, sh.major_radius};
              acc <= '0;
              state <= S_CYA;
            end
          end
          S_CYA: begin acc <= acc_next; state <= S_CYZ; end
          S_CYZ: begin
            rt_v <= acc_next; rt_res <= '0; rt_cnt <= 6'(RT_W - 1);
            rt_busy <= 1'b1; ret <= S_CYR;
          end
          S_CYR: begin sph <= rt_res[RT_W:0] + len3; state <= S_FOLD; end
          S_BX: begin acc <= acc_next; state <= S_BY; end
          S_BY: begin
            acc <= acc_next;
            rt_v <= acc_next; rt_res <= '0; rt_cnt <= 6'(RT_W - 1);
            rt_busy <= 1'b1; ret <= S_BR2;
          end
          S_BR2: begin circ <= rt_res[RT_W:0]; state <= S_BZ; end
          S_BZ: begin
            rt_v <= acc_next; rt_res <= '0; rt_cnt <= 6'(RT_W - 1);
            rt_busy <= 1'b1; ret <= S_BR3;
          end
          S_BR3: begin sph <= rt_res[RT_W:0]; state <= S_FOLD; end
          S_FOLD: begin
            if (sat(circ) > circle_max) circle_max <= sat(circ);
            if (sat(sph) > sphere_max) sphere_max <= sat(sph);
            state <= sh.last_shape ? S_EMIT : S_IDLE;
          end
          S_EMIT: if (!out_valid || bound_out.ready) begin
            out_data.circle_radius <= circle_max;
            out_data.sphere_radius <= sphere_max;
            circle_max <= CIRCLE_RESET;
            sphere_max <= '0;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule
